FILE: rtl/core/hss_pkg.sv
// Shared types, constants and helper functions of the HMAC-SHA256 signer.
// Depends on nothing; every other file of the block imports it.
package hss_pkg;

   localparam int KeyWords          = 8;
   localparam int KeyIndexWidth     = 3;
   localparam int CsrIndexWidth     = 4;
   localparam int QueueDepthDefault = 4;

   localparam logic [31:0] InnerPadWord = 32'h3636_3636;
   localparam logic [31:0] OuterPadWord = 32'h5c5c_5c5c;
   localparam logic [63:0] BlockBytes   = 64'd64;
   // Outer message is the 64-byte key block plus the 32-byte inner digest.
   localparam logic [31:0] OuterLenBits = 32'd768;

   typedef logic [31:0]                word_type;
   typedef word_type [7:0]             hash_type;
   typedef word_type [15:0]            block_type;
   typedef logic [KeyWords-1:0][63:0]  key_type;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       final_item;
      logic       no_byte;
   } item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cmp_stat_type;

   function automatic hash_type initial_hash();
      hash_type h;
      h[0] = 32'h6a09e667; h[1] = 32'hbb67ae85; h[2] = 32'h3c6ef372; h[3] = 32'ha54ff53a;
      h[4] = 32'h510e527f; h[5] = 32'h9b05688c; h[6] = 32'h1f83d9ab; h[7] = 32'h5be0cd19;
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic block_type key_block(input key_type key, input word_type pad);
      block_type b;
      for (int i = 0; i < KeyWords; i++) begin
         b[2*i]   = key[i][63:32] ^ pad;
         b[2*i+1] = key[i][31:0] ^ pad;
      end
      return b;
   endfunction

   function automatic word_type round_const(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/core/hss_channels.sv
// Handshake channel interfaces of the HMAC-SHA256 signer: request, response, register write.
// Depends on hss_pkg for the register index width.
interface hss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       final_item;
   logic       no_byte;
   modport source (output valid, message_byte, final_item, no_byte, input ready);
   modport sink   (input valid, message_byte, final_item, no_byte, output ready);
endinterface

interface hss_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word_0;
   logic [63:0] digest_word_1;
   logic [63:0] digest_word_2;
   logic [63:0] digest_word_3;
   modport source (output valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
                   input ready);
   modport sink   (input valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
                   output ready);
endinterface

interface hss_csr_if import hss_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [63:0]              data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/hss_compress.sv
// SHA-256 compression unit: one round per cycle over a rolling 16-word message schedule.
// Depends on hss_pkg for the hash and block types and the round constants.
module hss_compress import hss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  hash_type     h_in,
   input  block_type    blk_in,
   output hash_type     h_out,
   output cmp_stat_type stat
);

   block_type  w_ff, w_in;
   hash_type   v_ff, v_in;
   hash_type   base_ff, base_in;
   logic [5:0] round_ff, round_in;
   logic       busy_ff, busy_in;
   logic       fin_ff, fin_in;
   logic       done_ff, done_in;

   word_type t1, t2, w_next, ch, maj;

   always_comb begin
      ch     = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1     = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
               + ch + round_const(round_ff) + w_ff[0];
      t2     = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22)) + maj;
      w_next = w_ff[0] + (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3))
               + w_ff[9] + (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10));

      w_in     = w_ff;
      v_in     = v_ff;
      base_in  = base_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      if (start) begin
         w_in     = blk_in;
         v_in     = h_in;
         base_in  = h_in;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = w_next;
         v_in[0]  = t1 + t2;
         v_in[1]  = v_ff[0];
         v_in[2]  = v_ff[1];
         v_in[3]  = v_ff[2];
         v_in[4]  = v_ff[3] + t1;
         v_in[5]  = v_ff[4];
         v_in[6]  = v_ff[5];
         v_in[7]  = v_ff[6];
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = base_ff[i] + v_ff[i];
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      v_ff     <= v_in;
      base_ff  <= base_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   assign h_out     = v_ff;
   assign stat.busy = busy_ff | fin_ff;
   assign stat.done = done_ff;

endmodule

FILE: rtl/core/hss_queue.sv
// Small first-in first-out queue of message items between the front and back parts.
// Depends on hss_pkg for the item type.
module hss_queue import hss_pkg::*; #(
   parameter int Depth = QueueDepthDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   item_type              mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full     = (cnt_ff == CntWidth'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/hss_front.sv
// Front part: takes request transfers, drops empty items that do not end a message.
// Depends on hss_pkg and the request channel interface.
module hss_front import hss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hss_req_if.sink   req,
   output logic      push,
   output item_type  push_item,
   input  logic      full
);

   item_type item_ff;
   logic     valid_ff, valid_in;
   logic     take, keep;

   assign req.ready = !valid_ff || !full;
   assign take      = req.valid && req.ready;
   // An item with no byte matters only when it closes the message.
   assign keep      = !req.no_byte || req.final_item;
   assign push      = valid_ff;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff && full;
      if (take && keep) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{message_byte: req.message_byte, final_item: req.final_item,
                      no_byte: req.no_byte};
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: rtl/core/hss_back.sv
// Back part: sequences the inner and outer hashes, padding and the result register.
// Depends on hss_pkg, the response channel interface and hss_compress.
module hss_back import hss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  key_type   key,
   input  item_type  pop_item,
   input  logic      empty,
   output logic      pop,
   hss_rsp_if.source rsp
);

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_KEYI = 13'b0000000000010,
      S_KEYW = 13'b0000000000100,
      S_BYTE = 13'b0000000001000,
      S_MSG  = 13'b0000000010000,
      S_MSGW = 13'b0000000100000,
      S_PAD  = 13'b0000001000000,
      S_PADW = 13'b0000010000000,
      S_LEN  = 13'b0000100000000,
      S_INW  = 13'b0001000000000,
      S_OKEY = 13'b0010000000000,
      S_OKW  = 13'b0100000000000,
      S_OUT  = 13'b1000000000000
   } back_state_type;

   back_state_type state_ff, state_in;
   item_type       cur_ff, cur_in;
   hash_type       cv_ff, cv_in;
   block_type      buf_ff, buf_in;
   logic [63:0]    count_ff, count_in;
   logic           loaded_ff, loaded_in;
   hash_type       out_ff, out_in;
   logic           out_valid_ff, out_valid_in;
   logic           outer_fin_ff, outer_fin_in;

   logic           cmp_start;
   hash_type       cmp_h, cmp_out;
   block_type      cmp_blk;
   cmp_stat_type   cmp_stat;

   logic [5:0]     pos;
   logic [63:0]    len_bits;
   logic           one_block;
   logic           out_load;
   word_type       wr_word;
   block_type      pad_blk, len_blk, outer_blk;

   assign pos       = count_ff[5:0];
   assign len_bits  = {count_ff[60:0], 3'b000};
   // The 0x80 marker and the length fit together when the marker lands before byte 56.
   assign one_block = (pos <= 6'd55);
   assign out_load  = (state_ff == S_OUT) && (!out_valid_ff || rsp.ready);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (6'(4*i + j) < pos) begin
               pad_blk[i][8*(3-j) +: 8] = buf_ff[i][8*(3-j) +: 8];
            end else if (6'(4*i + j) == pos) begin
               pad_blk[i][8*(3-j) +: 8] = 8'h80;
            end else begin
               pad_blk[i][8*(3-j) +: 8] = 8'h00;
            end
         end
      end
      if (one_block) begin
         pad_blk[14] = len_bits[63:32];
         pad_blk[15] = len_bits[31:0];
      end
      len_blk     = '0;
      len_blk[14] = len_bits[63:32];
      len_blk[15] = len_bits[31:0];
      outer_blk   = '0;
      for (int i = 0; i < 8; i++) begin
         outer_blk[i] = cv_ff[i];
      end
      outer_blk[8]  = 32'h8000_0000;
      outer_blk[15] = OuterLenBits;
   end

   always_comb begin
      wr_word = (pos[1:0] == 2'b00) ? '0 : buf_ff[pos[5:2]];
      wr_word[8*(3 - int'(pos[1:0])) +: 8] = cur_ff.message_byte;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cv_in        = cv_ff;
      buf_in       = buf_ff;
      count_in     = count_ff;
      loaded_in    = loaded_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      outer_fin_in = outer_fin_ff;
      pop          = 1'b0;
      cmp_start    = 1'b0;
      cmp_h        = cv_ff;
      cmp_blk      = buf_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               cur_in   = pop_item;
               state_in = loaded_ff ? S_BYTE : S_KEYI;
            end
         end
         S_KEYI: begin
            cmp_start = 1'b1;
            cmp_h     = initial_hash();
            cmp_blk   = key_block(key, InnerPadWord);
            state_in  = S_KEYW;
         end
         S_KEYW: begin
            if (cmp_stat.done) begin
               cv_in     = cmp_out;
               count_in  = BlockBytes;
               loaded_in = 1'b1;
               state_in  = S_BYTE;
            end
         end
         S_BYTE: begin
            if (!cur_ff.no_byte) begin
               buf_in[pos[5:2]] = wr_word;
               count_in         = count_ff + 64'd1;
            end
            if (!cur_ff.no_byte && pos == 6'd63) begin
               state_in = S_MSG;
            end else if (cur_ff.final_item) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MSG: begin
            cmp_start = 1'b1;
            state_in  = S_MSGW;
         end
         S_MSGW: begin
            if (cmp_stat.done) begin
               cv_in    = cmp_out;
               state_in = cur_ff.final_item ? S_PAD : S_IDLE;
            end
         end
         S_PAD: begin
            cmp_start = 1'b1;
            cmp_blk   = pad_blk;
            state_in  = one_block ? S_INW : S_PADW;
         end
         S_PADW: begin
            if (cmp_stat.done) begin
               cv_in    = cmp_out;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            cmp_start = 1'b1;
            cmp_blk   = len_blk;
            state_in  = S_INW;
         end
         S_INW: begin
            if (cmp_stat.done) begin
               cv_in    = cmp_out;
               state_in = S_OKEY;
            end
         end
         S_OKEY: begin
            cmp_start    = 1'b1;
            cmp_h        = initial_hash();
            cmp_blk      = key_block(key, OuterPadWord);
            outer_fin_in = 1'b0;
            state_in     = S_OKW;
         end
         S_OKW: begin
            // First pass hashes the outer key block, second the inner digest.
            if (cmp_stat.done) begin
               if (!outer_fin_ff) begin
                  cmp_start    = 1'b1;
                  cmp_h        = cmp_out;
                  cmp_blk      = outer_blk;
                  outer_fin_in = 1'b1;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (out_load) begin
               out_in       = cmp_out;
               out_valid_in = 1'b1;
               count_in     = '0;
               loaded_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      cv_ff  <= cv_in;
      buf_ff <= buf_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         loaded_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         outer_fin_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         loaded_ff    <= loaded_in;
         out_valid_ff <= out_valid_in;
         outer_fin_ff <= outer_fin_in;
      end
   end

   hss_compress u_compress (
      .clock  (clock),
      .reset  (reset),
      .start  (cmp_start),
      .h_in   (cmp_h),
      .blk_in (cmp_blk),
      .h_out  (cmp_out),
      .stat   (cmp_stat)
   );

   assign rsp.valid         = out_valid_ff;
   assign rsp.digest_word_0 = {out_ff[0], out_ff[1]};
   assign rsp.digest_word_1 = {out_ff[2], out_ff[3]};
   assign rsp.digest_word_2 = {out_ff[4], out_ff[5]};
   assign rsp.digest_word_3 = {out_ff[6], out_ff[7]};

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmp_start |-> !cmp_stat.busy)
      else $error("compression started while the unit was busy");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (!loaded_ff && count_ff == '0 && out_valid_ff))
      else $error("message state not cleared when the result was loaded");

   a_key_block_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEYW && cmp_stat.done) |=> (count_ff == BlockBytes && loaded_ff))
      else $error("byte count wrong after the inner key block");

endmodule

FILE: rtl/core/hmac_sha256_signer.sv
// Top level of the HMAC-SHA256 signer: key registers, front, queue and back parts.
// Depends on hss_pkg, hss_channels, hss_front, hss_queue and hss_back.
//
// This block computes HMAC-SHA256 over a message that arrives one byte per request transfer,
// under a 64-byte key held in eight 64-bit registers written through the csr channel (register
// i holds key bytes 8i to 8i+7, lowest byte most significant; writes to an index beyond seven
// are ignored). A request with no_byte set and final_item clear is dropped; final_item closes
// the message, with or without a byte, and an empty message is closed by a request that has
// both set. Exactly one response transfer follows each closed message and carries the 32-byte
// digest in four 64-bit words. The front part registers each request and places it in a short
// queue, so requests keep flowing while the back part hashes. The back part takes the bytes one
// at a time, and its compression unit runs one SHA-256 round per cycle over each 64-byte block;
// the first byte of a message also waits for the inner key block, and the end of a message
// costs three or four compressions before the digest is shown. Sustained throughput on a long
// message is set by the sequencer and the shared compression unit. A finished digest sits in an
// output register, so the next message may start while that response transfer is still pending.
// The key registers must only be written while the block is idle.
module hmac_sha256_signer import hss_pkg::*; #(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   hss_req_if.sink    req_chan,
   hss_rsp_if.source  rsp_chan,
   hss_csr_if.sink    csr_chan
);

   key_type  key_ff;
   logic     q_push, q_full, q_pop, q_empty;
   item_type q_push_item, q_pop_item;

   // Register writes are always taken; out-of-range indexes fall away.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_chan.valid && csr_chan.index < CsrIndexWidth'(KeyWords)) begin
         key_ff[csr_chan.index[KeyIndexWidth-1:0]] <= csr_chan.data;
      end
   end

   hss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full)
   );

   hss_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   hss_back u_back (
      .clock    (clock),
      .reset    (reset),
      .key      (key_ff),
      .pop_item (q_pop_item),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp      (rsp_chan)
   );

endmodule
